// ----- rtl/bsoc_pkg.sv -----
// ----------------------------------------------------------------------------
// bsoc_pkg: shared types and constants
// Discharge-curve table, field widths and pipeline control struct for the
// battery state-of-charge interpolator.
// ----------------------------------------------------------------------------
package bsoc_pkg;

	// table geometry
	localparam int TABLE_POINTS = 11;
	localparam int SEGS         = TABLE_POINTS - 1;
	localparam int SOC_FULL     = 1000;
	localparam int SEG_SPAN     = SOC_FULL / SEGS;

	// field and datapath widths
	localparam int PACK_W  = 17;  // pack voltage, mV
	localparam int CNT_W   = 6;   // series cell count
	localparam int MV_W    = 13;  // one table point, mV
	localparam int TH_W    = 19;  // table point times cell count
	localparam int DIFF_W  = 9;   // widest segment drop, mV
	localparam int SPAN_W  = 15;  // segment drop times cell count
	localparam int NUM_W   = 22;  // offset into segment times SEG_SPAN
	localparam int Q_W     = 7;   // per-mille within one segment
	localparam int SOC_W   = 10;
	localparam int SEG_W   = 4;

	localparam logic [CNT_W-1:0] CELL_COUNT_RESET = CNT_W'(12);

	// front stages, divider stages, output register
	localparam int FRONT_STAGES = 5;
	localparam int PIPE_LATENCY = FRONT_STAGES + Q_W + 1;

	typedef struct packed {
		logic             valid;
		logic             top;   // at or above the highest point
		logic             bot;   // at or below the lowest point
		logic [SEG_W-1:0] seg;
		logic [SOC_W-1:0] base;  // per-mille at the lower end of the segment
	} bsoc_ctl_t;

	// discharge curve, highest point first
	function automatic logic [MV_W-1:0] curve_mv(input int idx);
		logic [MV_W-1:0] v;
		case (idx)
			0:       v = MV_W'(4200);
			1:       v = MV_W'(4054);
			2:       v = MV_W'(4010);
			3:       v = MV_W'(3908);
			4:       v = MV_W'(3827);
			5:       v = MV_W'(3740);
			6:       v = MV_W'(3651);
			7:       v = MV_W'(3571);
			8:       v = MV_W'(3485);
			9:       v = MV_W'(3380);
			10:      v = MV_W'(3000);
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic logic [DIFF_W-1:0] curve_diff(input int seg);
		logic [MV_W-1:0] d;
		d = curve_mv(seg) - curve_mv(seg + 1);
		return d[DIFF_W-1:0];
	endfunction

endpackage

// ----- rtl/bsoc_locate.sv -----
// ----------------------------------------------------------------------------
// bsoc_locate: segment search and span setup
// Scales the table by the cell count, finds the segment that holds the pack
// voltage and forms the division operands for the in-segment fraction.
// ----------------------------------------------------------------------------
module bsoc_locate (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic [bsoc_pkg::PACK_W-1:0]    pack_voltage_mv,
	input  logic [bsoc_pkg::CNT_W-1:0]     cell_count,
	output bsoc_pkg::bsoc_ctl_t            ctl,
	output logic [bsoc_pkg::NUM_W-1:0]     num,
	output logic [bsoc_pkg::SPAN_W-1:0]    den
);

	localparam int TP = bsoc_pkg::TABLE_POINTS;

	// stage 1
	logic                          valid_s1;
	logic [bsoc_pkg::PACK_W-1:0]   pack_s1;

	// stage 2
	logic                          valid_s2;
	logic [bsoc_pkg::PACK_W-1:0]   pack_s2;
	logic [bsoc_pkg::CNT_W-1:0]    n_s2;
	logic [TP-1:0]                 gt_s2;
	logic                          top_s2;

	// stage 3
	logic                          valid_s3;
	logic                          top_s3;
	logic                          bot_s3;
	logic [bsoc_pkg::SEG_W-1:0]    seg_s3;
	logic [bsoc_pkg::PACK_W-1:0]   pack_s3;
	logic [bsoc_pkg::CNT_W-1:0]    n_s3;

	// stage 4
	bsoc_pkg::bsoc_ctl_t           ctl_s4;
	logic [bsoc_pkg::SPAN_W-1:0]   r_s4;
	logic [bsoc_pkg::SPAN_W-1:0]   p_s4;

	// stage 5
	bsoc_pkg::bsoc_ctl_t           ctl_s5;
	logic [bsoc_pkg::SPAN_W-1:0]   r_s5;
	logic [bsoc_pkg::NUM_W-1:0]    num_s5;

	logic [bsoc_pkg::CNT_W-1:0]    n_c;
	logic [bsoc_pkg::TH_W-1:0]     th_c [TP];
	logic [TP-1:0]                 gt_c;
	logic                          top_c;
	logic [bsoc_pkg::SEG_W-1:0]    seg_c;
	logic [bsoc_pkg::TH_W-1:0]     lo_c;
	logic [bsoc_pkg::TH_W-1:0]     off_c;
	logic [bsoc_pkg::SPAN_W-1:0]   r_c;
	logic [bsoc_pkg::SOC_W-1:0]    base_c;

	// a cell count of zero counts as one cell
	assign n_c = (cell_count == '0) ? bsoc_pkg::CNT_W'(1) : cell_count;

	always_comb begin
		for (int i = 0; i < TP; i++) begin
			th_c[i] = bsoc_pkg::TH_W'(bsoc_pkg::curve_mv(i)) * bsoc_pkg::TH_W'(n_c);
			gt_c[i] = bsoc_pkg::TH_W'(pack_s1) > th_c[i];
		end
		top_c = bsoc_pkg::TH_W'(pack_s1) >= th_c[0];
	end

	// gt is a thermometer code; the segment sits at its edge
	always_comb begin
		seg_c = bsoc_pkg::SEG_W'(bsoc_pkg::SEGS - 1);
		for (int j = 0; j < bsoc_pkg::SEGS; j++) begin
			if (!gt_s2[j] && gt_s2[j+1]) begin
				seg_c = bsoc_pkg::SEG_W'(j);
			end
		end
	end

	always_comb begin
		lo_c   = bsoc_pkg::TH_W'(bsoc_pkg::curve_mv(int'(seg_s3) + 1)) *
		         bsoc_pkg::TH_W'(n_s3);
		off_c  = bsoc_pkg::TH_W'(pack_s3) - lo_c;
		r_c    = bsoc_pkg::SPAN_W'(bsoc_pkg::curve_diff(int'(seg_s3))) *
		         bsoc_pkg::SPAN_W'(n_s3);
		base_c = bsoc_pkg::SOC_W'((bsoc_pkg::SEGS - 1 - int'(seg_s3)) * bsoc_pkg::SEG_SPAN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			ctl_s4   <= '0;
			ctl_s5   <= '0;
		end else begin
			valid_s1     <= in_valid;
			valid_s2     <= valid_s1;
			valid_s3     <= valid_s2;
			ctl_s4.valid <= valid_s3;
			ctl_s4.top   <= top_s3;
			ctl_s4.bot   <= bot_s3;
			ctl_s4.seg   <= seg_s3;
			ctl_s4.base  <= base_c;
			ctl_s5       <= ctl_s4;
		end
	end

	always_ff @(posedge clk) begin
		pack_s1 <= pack_voltage_mv;

		pack_s2 <= pack_s1;
		n_s2    <= n_c;
		gt_s2   <= gt_c;
		top_s2  <= top_c;

		top_s3  <= top_s2;
		bot_s3  <= !gt_s2[TP-1];
		seg_s3  <= seg_c;
		pack_s3 <= pack_s2;
		n_s3    <= n_s2;

		r_s4    <= r_c;
		p_s4    <= off_c[bsoc_pkg::SPAN_W-1:0];

		r_s5    <= r_s4;
		num_s5  <= bsoc_pkg::NUM_W'(p_s4) * bsoc_pkg::NUM_W'(bsoc_pkg::SEG_SPAN);
	end

	assign ctl = ctl_s5;
	assign num = num_s5;
	assign den = r_s5;

endmodule

// ----- rtl/bsoc_div.sv -----
// ----------------------------------------------------------------------------
// bsoc_div: pipelined restoring divider
// One quotient bit per stage; control travels alongside each operand pair.
// ----------------------------------------------------------------------------
module bsoc_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bsoc_pkg::bsoc_ctl_t            ctl_in,
	input  logic [bsoc_pkg::NUM_W-1:0]     num,
	input  logic [bsoc_pkg::SPAN_W-1:0]    den,
	output bsoc_pkg::bsoc_ctl_t            ctl_out,
	output logic [bsoc_pkg::Q_W-1:0]       quot
);

	localparam int QW = bsoc_pkg::Q_W;

	// index k is the register after stage k; the last stage keeps no remainder
	bsoc_pkg::bsoc_ctl_t           ctl_stg  [QW];
	logic [bsoc_pkg::NUM_W-1:0]    rem_stg  [QW-1];
	logic [bsoc_pkg::SPAN_W-1:0]   den_stg  [QW-1];
	logic [QW-1:0]                 quot_stg [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		localparam int B = QW - 1 - k;

		bsoc_pkg::bsoc_ctl_t         ctl_d;
		logic [bsoc_pkg::NUM_W-1:0]  rem_d;
		logic [bsoc_pkg::SPAN_W-1:0] den_d;
		logic [QW-1:0]               quot_d;
		logic [bsoc_pkg::NUM_W-1:0]  dvs;
		logic                        fit;

		if (k == 0) begin : g_head
			assign ctl_d  = ctl_in;
			assign rem_d  = num;
			assign den_d  = den;
			assign quot_d = '0;
		end else begin : g_link
			assign ctl_d  = ctl_stg[k-1];
			assign rem_d  = rem_stg[k-1];
			assign den_d  = den_stg[k-1];
			assign quot_d = quot_stg[k-1];
		end

		assign dvs = bsoc_pkg::NUM_W'(den_d) << B;
		assign fit = rem_d >= dvs;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_stg[k] <= '0;
			end else begin
				ctl_stg[k] <= ctl_d;
			end
		end

		always_ff @(posedge clk) begin
			quot_stg[k] <= {quot_d[QW-2:0], fit};
		end

		if (k < QW - 1) begin : g_carry
			always_ff @(posedge clk) begin
				den_stg[k] <= den_d;
				rem_stg[k] <= fit ? (rem_d - dvs) : rem_d;
			end
		end
	end

	assign ctl_out = ctl_stg[QW-1];
	assign quot    = quot_stg[QW-1];

endmodule

// ----- rtl/battery_soc_interpolator_top.sv -----
// ----------------------------------------------------------------------------
// battery_soc_interpolator_top: battery state-of-charge lookup
// Pack voltage in, per-mille state of charge out, by linear interpolation on
// a fixed discharge curve scaled by the configured series cell count.
// ----------------------------------------------------------------------------
// A new sample is taken in every clock cycle (start while busy is low) and
// its result appears on done after the segment search and operand setup
// stages, the one-bit-per-stage quotient pipeline and one output register.
// busy is high only during reset and until the first clock edge after reset
// is released. Results are shown for one cycle on the done strobe and cannot
// be held off. Write cell_count only while no sample is in flight.
module battery_soc_interpolator_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [bsoc_pkg::PACK_W-1:0]    pack_voltage_mv,
	input  logic                           cfg_write,
	input  logic [bsoc_pkg::CNT_W-1:0]     cfg_data,
	output logic                           done,
	output logic [bsoc_pkg::SOC_W-1:0]     soc_permille,
	output logic [bsoc_pkg::SEG_W-1:0]     segment_index,
	output logic                           out_of_range
);

	logic [bsoc_pkg::CNT_W-1:0]    cell_count_q;
	logic                          busy_q;
	logic                          done_q;
	logic [bsoc_pkg::SOC_W-1:0]    soc_q;
	logic [bsoc_pkg::SEG_W-1:0]    seg_q;
	logic                          oor_q;

	bsoc_pkg::bsoc_ctl_t           loc_ctl;
	logic [bsoc_pkg::NUM_W-1:0]    loc_num;
	logic [bsoc_pkg::SPAN_W-1:0]   loc_den;
	bsoc_pkg::bsoc_ctl_t           div_ctl;
	logic [bsoc_pkg::Q_W-1:0]      div_quot;
	logic                          accept;

	assign accept = start && !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_count_q <= bsoc_pkg::CELL_COUNT_RESET;
			busy_q       <= 1'b1;
			done_q       <= 1'b0;
		end else begin
			if (cfg_write) begin
				cell_count_q <= cfg_data;
			end
			busy_q <= 1'b0;
			done_q <= div_ctl.valid;
		end
	end

	bsoc_locate u_locate (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (accept),
		.pack_voltage_mv (pack_voltage_mv),
		.cell_count      (cell_count_q),
		.ctl             (loc_ctl),
		.num             (loc_num),
		.den             (loc_den)
	);

	bsoc_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_in  (loc_ctl),
		.num     (loc_num),
		.den     (loc_den),
		.ctl_out (div_ctl),
		.quot    (div_quot)
	);

	// clamp to the table ends, otherwise segment base plus fraction
	always_ff @(posedge clk) begin
		if (div_ctl.top) begin
			soc_q <= bsoc_pkg::SOC_W'(bsoc_pkg::SOC_FULL);
			seg_q <= '0;
		end else if (div_ctl.bot) begin
			soc_q <= '0;
			seg_q <= bsoc_pkg::SEG_W'(bsoc_pkg::SEGS - 1);
		end else begin
			soc_q <= div_ctl.base + bsoc_pkg::SOC_W'(div_quot);
			seg_q <= div_ctl.seg;
		end
		oor_q <= div_ctl.top || div_ctl.bot;
	end

	assign busy          = busy_q;
	assign done          = done_q;
	assign soc_permille  = soc_q;
	assign segment_index = seg_q;
	assign out_of_range  = oor_q;

endmodule

// ----- rtl/bsoc_checker.sv -----
// ----------------------------------------------------------------------------
// bsoc_checker: port-level checks
// Latency, clamping and segment-range consistency seen on the top ports.
// ----------------------------------------------------------------------------
module bsoc_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           busy,
	input  logic                           done,
	input  logic [bsoc_pkg::SOC_W-1:0]     soc_permille,
	input  logic [bsoc_pkg::SEG_W-1:0]     segment_index,
	input  logic                           out_of_range
);

	localparam int LAT = bsoc_pkg::PIPE_LATENCY;

	// every accepted transaction produces a result after the fixed latency
	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("result missing after accepted transaction");

	a_latency_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without matching transaction");

	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		done && out_of_range |->
			(soc_permille == '0 && segment_index == bsoc_pkg::SEG_W'(bsoc_pkg::SEGS - 1)) ||
			(soc_permille == bsoc_pkg::SOC_W'(bsoc_pkg::SOC_FULL) && segment_index == '0))
		else $error("out-of-range result not clamped to a table end");

	a_in_segment: assert property (@(posedge clk) disable iff (!arst_n)
		done && !out_of_range |->
			int'(segment_index) < bsoc_pkg::SEGS &&
			int'(soc_permille) >=
				(bsoc_pkg::SEGS - 1 - int'(segment_index)) * bsoc_pkg::SEG_SPAN &&
			int'(soc_permille) <=
				(bsoc_pkg::SEGS - int'(segment_index)) * bsoc_pkg::SEG_SPAN)
		else $error("state of charge outside its segment range");

endmodule

bind battery_soc_interpolator_top bsoc_checker u_bsoc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.soc_permille  (soc_permille),
	.segment_index (segment_index),
	.out_of_range  (out_of_range)
);
